// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the branch target buffer.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/btb_pkg.sv
// Shared types, constants and codes of the branch target buffer.
// Depends on nothing.
`default_nettype none
package btb_pkg;

    localparam int MAX_ENTRIES     = 32;
    localparam int ENTRY_W         = 5;
    localparam int MAX_HISTORY     = 8;
    localparam int HIST_W          = 8;
    localparam int HLEN_W          = 4;
    localparam int MAX_TAG         = 30;
    localparam int TAG_W           = 30;
    localparam int TLEN_W          = 5;
    localparam int ADDR_W          = 32;
    localparam int TABLE_DEPTH     = MAX_ENTRIES << MAX_HISTORY;
    localparam int SLOT_W          = 13;
    localparam int CNT_W           = 2;
    localparam int STORAGE_W       = 15;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 2'd3;
    localparam logic [CNT_W-1:0]  CNT_TAKEN  = 2'd2;
    localparam logic [ADDR_W-1:0] INSN_BYTES = 32'd4;
    localparam int NEAR_SHARE_SHIFT = 2;
    localparam int FAR_SHARE_SHIFT  = 16;

    typedef enum logic [2:0] {
        REG_ENTRIES_LOG2   = 3'd0,
        REG_HISTORY_BITS   = 3'd1,
        REG_TAG_BITS       = 3'd2,
        REG_INITIAL_STATE  = 3'd3,
        REG_GLOBAL_HISTORY = 3'd4,
        REG_GLOBAL_TABLE   = 3'd5,
        REG_SHARE_MODE     = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        SHARE_NONE = 2'd0,
        SHARE_NEAR = 2'd1,
        SHARE_FAR  = 2'd2
    } share_t;

    typedef enum logic {
        FUNC_PREDICT = 1'b0,
        FUNC_UPDATE  = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_RELOAD,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] resolved_target;
        logic              outcome_taken;
        logic [ADDR_W-1:0] earlier_prediction;
    } req_t;

    typedef struct packed {
        logic                 predict_taken;
        logic [ADDR_W-1:0]    predicted_address;
        logic [31:0]          branch_count;
        logic [31:0]          flush_count;
        logic [STORAGE_W-1:0] storage_bits;
    } rsp_t;

    // Effective (saturated) configuration seen by the datapath
    typedef struct packed {
        logic [2:0]        entries_log2;
        logic [HLEN_W-1:0] hist_len;
        logic [TLEN_W-1:0] tag_len;
        logic [CNT_W-1:0]  init_state;
        logic              global_history;
        logic              global_table;
        share_t            share_mode;
    } cfg_t;

endpackage
`default_nettype wire

// File: rtl/btb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module btb_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/btb_slot_unit.sv
// Shared counter-table address unit: table base shifted by history length plus offset.
// Depends on btb_pkg.
`default_nettype none
module btb_slot_unit (
    input  wire logic [btb_pkg::ENTRY_W-1:0] base,
    input  wire logic [btb_pkg::HIST_W-1:0]  offset,
    input  wire logic [btb_pkg::HLEN_W-1:0]  hist_len,
    output logic      [btb_pkg::SLOT_W-1:0]  slot
);
    import btb_pkg::*;

    logic [SLOT_W-1:0] base_ext;
    logic [SLOT_W-1:0] base_shift;

    // Place the table at base << hist_len and add the counter offset
    always_comb
    begin
        base_ext   = SLOT_W'(base);
        base_shift = base_ext << hist_len;
        slot       = base_shift + SLOT_W'(offset);
    end

endmodule
`default_nettype wire

// File: rtl/btb_cfg_regs.sv
// APB register file of the branch target buffer, with effective values and storage size.
// Depends on btb_pkg.
`default_nettype none
module btb_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [btb_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [btb_pkg::PDATA_W-1:0]     pwdata,
    output logic      [btb_pkg::PDATA_W-1:0]     prdata,
    output logic                                 pready,
    output btb_pkg::cfg_t                        cfg,
    output logic                                 cfg_write,
    output logic      [btb_pkg::STORAGE_W-1:0]   storage_bits
);
    import btb_pkg::*;

    logic [2:0]        entries_log2_reg;
    logic [HLEN_W-1:0] history_bits_reg;
    logic [TLEN_W-1:0] tag_bits_reg;
    logic [CNT_W-1:0]  initial_state_reg;
    logic              global_history_reg;
    logic              global_table_reg;
    logic [1:0]        share_mode_reg;
    logic [STORAGE_W-1:0] storage_reg;
    logic [STORAGE_W-1:0] storage_next;

    reg_idx_t reg_idx;
    logic     wr_hit;
    logic [STORAGE_W-1:0] entry_part;
    logic [STORAGE_W-1:0] hist_part;
    logic [STORAGE_W-1:0] table_part;
    logic [2:0]           hreg_shift;
    logic [3:0]           table_shift;

    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign pready  = 1'b1;
    assign wr_hit  = psel && penable && pwrite && (paddr[4:2] <= 3'(REG_SHARE_MODE));
    assign cfg_write = wr_hit;

    // Write the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_log2_reg   <= 3'd5;
            history_bits_reg   <= 4'd8;
            tag_bits_reg       <= 5'd30;
            initial_state_reg  <= 2'd1;
            global_history_reg <= 1'b0;
            global_table_reg   <= 1'b0;
            share_mode_reg     <= 2'd0;
        end
        else if (wr_hit)
        begin
            case (reg_idx)
                REG_ENTRIES_LOG2:   entries_log2_reg   <= pwdata[2:0];
                REG_HISTORY_BITS:   history_bits_reg   <= pwdata[3:0];
                REG_TAG_BITS:       tag_bits_reg       <= pwdata[4:0];
                REG_INITIAL_STATE:  initial_state_reg  <= pwdata[1:0];
                REG_GLOBAL_HISTORY: global_history_reg <= pwdata[0];
                REG_GLOBAL_TABLE:   global_table_reg   <= pwdata[0];
                REG_SHARE_MODE:     share_mode_reg     <= pwdata[1:0];
                default:            ;
            endcase
        end
    end

    // Read back raw register values
    always_comb
    begin
        case (reg_idx)
            REG_ENTRIES_LOG2:   prdata = PDATA_W'(entries_log2_reg);
            REG_HISTORY_BITS:   prdata = PDATA_W'(history_bits_reg);
            REG_TAG_BITS:       prdata = PDATA_W'(tag_bits_reg);
            REG_INITIAL_STATE:  prdata = PDATA_W'(initial_state_reg);
            REG_GLOBAL_HISTORY: prdata = PDATA_W'(global_history_reg);
            REG_GLOBAL_TABLE:   prdata = PDATA_W'(global_table_reg);
            REG_SHARE_MODE:     prdata = PDATA_W'(share_mode_reg);
            default:            prdata = '0;
        endcase
    end

    // Saturate the registers into their working ranges
    always_comb
    begin
        cfg.entries_log2 = (entries_log2_reg > 3'd5) ? 3'd5 : entries_log2_reg;
        if (history_bits_reg == 4'd0)
        begin
            cfg.hist_len = 4'd1;
        end
        else if (history_bits_reg > 4'(MAX_HISTORY))
        begin
            cfg.hist_len = 4'(MAX_HISTORY);
        end
        else
        begin
            cfg.hist_len = history_bits_reg;
        end
        cfg.tag_len        = (tag_bits_reg > 5'(MAX_TAG)) ? 5'(MAX_TAG) : tag_bits_reg;
        cfg.init_state     = initial_state_reg;
        cfg.global_history = global_history_reg;
        cfg.global_table   = global_table_reg;
        case (share_mode_reg)
            SHARE_NEAR: cfg.share_mode = SHARE_NEAR;
            SHARE_FAR:  cfg.share_mode = SHARE_FAR;
            default:    cfg.share_mode = SHARE_NONE;
        endcase
    end

    // Storage size: all products are shifts by powers of two
    always_comb
    begin
        hreg_shift   = cfg.global_history ? 3'd0 : cfg.entries_log2;
        table_shift  = 4'(cfg.hist_len) + 4'd1 + (cfg.global_table ? 4'd0
                                                   : 4'(cfg.entries_log2));
        entry_part   = (STORAGE_W'(cfg.tag_len) + STORAGE_W'(ADDR_W - 1)) << cfg.entries_log2;
        hist_part    = STORAGE_W'(cfg.hist_len) << hreg_shift;
        table_part   = STORAGE_W'(1) << table_shift;
        storage_next = entry_part + hist_part + table_part;
    end

    always_ff @(posedge clk)
    begin
        storage_reg <= storage_next;
    end

    assign storage_bits = storage_reg;

endmodule
`default_nettype wire

// File: rtl/btb_two_level_branch_predictor.sv
// Top level of the branch target buffer: sequencer, entry store and counter table.
// Depends on btb_pkg, btb_ram, btb_slot_unit, btb_cfg_regs and assert_macros.svh.
//
//  port group     | direction | handshake              | word
//  ---------------+-----------+------------------------+--------------------------------
//  req            | in        | req_valid / req_ready  | btb_pkg::req_t (predict/update)
//  rsp            | out       | rsp_valid / rsp_ready  | btb_pkg::rsp_t (one per request)
//  APB            | in/out    | psel, penable, pready  | 32-bit config registers
//
// A word passes through accept, entry check, counter read and response; an update that
// allocates an entry with per-entry history and per-entry tables also reloads that
// entry's table through the single write port of the counter RAM.
// After reset and after every register write the whole counter RAM is swept,
// with req_ready low. A waiting response holds the sequencer in its response step.
`default_nettype none
`include "assert_macros.svh"
module btb_two_level_branch_predictor (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [btb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [btb_pkg::PDATA_W-1:0] pwdata,
    output logic      [btb_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire btb_pkg::req_t               req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output btb_pkg::rsp_t                    rsp
);
    import btb_pkg::*;

    cfg_t                 cfg;
    logic                 cfg_write;
    logic [STORAGE_W-1:0] storage_bits;

    state_t state_reg, state_next;

    req_t                req_reg;
    logic                valid_reg [MAX_ENTRIES];
    logic [TAG_W-1:0]    tag_reg   [MAX_ENTRIES];
    logic [ADDR_W-1:0]   target_reg[MAX_ENTRIES];
    logic [HIST_W-1:0]   hist_reg  [MAX_ENTRIES];
    logic [ENTRY_W-1:0]  idx_reg;
    logic                hit_reg;
    logic [SLOT_W-1:0]   clr_reg;
    logic [HIST_W-1:0]   k_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [31:0]         branch_reg;
    logic [31:0]         flush_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    logic [ENTRY_W-1:0]  idx_c;
    logic [TAG_W-1:0]    tag_c;
    logic                new_entry;
    logic                need_reload;
    logic                mispredict;
    logic [ADDR_W-1:0]   fall_c;
    logic [HIST_W-1:0]   hmask;
    logic [HIST_W-1:0]   share_c;
    logic [HIST_W-1:0]   hist_sel;
    logic [ENTRY_W-1:0]  unit_base;
    logic [HIST_W-1:0]   unit_offset;
    logic [SLOT_W-1:0]   unit_slot;
    logic                is_update;
    logic                rsp_load;
    logic [CNT_W-1:0]    cnt_rd;
    logic [CNT_W-1:0]    cnt_new;
    logic [ENTRY_W-1:0]  hreg_idx;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [CNT_W-1:0]    ram_wdata;
    logic                ram_re;

    btb_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cfg          (cfg),
        .cfg_write    (cfg_write),
        .storage_bits (storage_bits)
    );

    // Entry index, tag and shared address inputs for the held word
    always_comb
    begin
        fall_c    = req_reg.pc + INSN_BYTES;
        is_update = (req_reg.func == FUNC_UPDATE);
        idx_c     = req_reg.pc[ENTRY_W+1:2] & ~({ENTRY_W{1'b1}} << cfg.entries_log2);
        tag_c     = TAG_W'(req_reg.pc >> (3'd2 + cfg.entries_log2))
                    & ~({TAG_W{1'b1}} << cfg.tag_len);
        new_entry = !valid_reg[idx_c] || (tag_reg[idx_c] != tag_c);
        need_reload = is_update && new_entry && !cfg.global_history && !cfg.global_table;
        mispredict = req_reg.outcome_taken ? (req_reg.earlier_prediction
                                              != req_reg.resolved_target)
                                           : (req_reg.earlier_prediction != fall_c);
        hmask     = ~({HIST_W{1'b1}} << cfg.hist_len);
        case (cfg.share_mode)
            SHARE_NEAR: share_c = req_reg.pc[NEAR_SHARE_SHIFT+HIST_W-1:NEAR_SHARE_SHIFT];
            SHARE_FAR:  share_c = req_reg.pc[FAR_SHARE_SHIFT+HIST_W-1:FAR_SHARE_SHIFT];
            default:    share_c = '0;
        endcase
        hist_sel  = cfg.global_history ? hist_reg[0] : hist_reg[idx_reg];
        hreg_idx  = cfg.global_history ? '0 : idx_reg;
        if (state_reg == ST_RELOAD)
        begin
            unit_base   = idx_reg;
            unit_offset = k_reg;
        end
        else
        begin
            unit_base   = cfg.global_table ? '0 : idx_reg;
            unit_offset = (hist_sel & hmask) ^ (share_c & hmask);
        end
    end

    btb_slot_unit u_slot (
        .base     (unit_base),
        .offset   (unit_offset),
        .hist_len (cfg.hist_len),
        .slot     (unit_slot)
    );

    // Saturating counter step
    always_comb
    begin
        cnt_new = cnt_rd;
        if (req_reg.outcome_taken)
        begin
            if (cnt_rd != CNT_MAX)
            begin
                cnt_new = cnt_rd + 2'd1;
            end
        end
        else if (cnt_rd != '0)
        begin
            cnt_new = cnt_rd - 2'd1;
        end
    end

    assign rsp_load = (state_reg == ST_RESP) && (!rsp_valid_reg || rsp_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_reg == {SLOT_W{1'b1}}) state_next = ST_IDLE;
            ST_IDLE:   if (req_valid) state_next = ST_CALC;
            ST_CALC:   state_next = need_reload ? ST_RELOAD : ST_READ;
            ST_RELOAD: if (k_reg == hmask) state_next = ST_READ;
            ST_READ:   state_next = ST_RESP;
            ST_RESP:   if (rsp_load) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
        if (cfg_write)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Sequencer outputs: RAM port control and input ready
    always_comb
    begin
        req_ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = unit_slot;
        ram_wdata = cfg.init_state;
        ram_re    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            ST_IDLE:   req_ready = 1'b1;
            ST_RELOAD: ram_we = 1'b1;
            ST_READ:   ram_re = 1'b1;
            ST_RESP:
            begin
                ram_we    = rsp_load && is_update;
                ram_waddr = slot_reg;
                ram_wdata = cnt_new;
            end
            default:   ;
        endcase
    end

    btb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (unit_slot),
        .rd_data (cnt_rd)
    );

    // Control state, entry valid bits, histories and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            branch_reg    <= '0;
            flush_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                hist_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_valid_reg && rsp_ready && !rsp_load)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            if (cfg_write)
            begin
                clr_reg    <= '0;
                branch_reg <= '0;
                flush_reg  <= '0;
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    valid_reg[i] <= 1'b0;
                    hist_reg[i]  <= '0;
                end
            end
            else
            begin
                case (state_reg)
                    ST_CLEAR:  clr_reg <= clr_reg + 1'b1;
                    ST_CALC:
                    begin
                        k_reg <= '0;
                        if (is_update)
                        begin
                            branch_reg <= branch_reg + 32'd1;
                            if (mispredict)
                            begin
                                flush_reg <= flush_reg + 32'd1;
                            end
                            if (new_entry && !cfg.global_history)
                            begin
                                hist_reg[idx_c] <= '0;
                            end
                            valid_reg[idx_c] <= 1'b1;
                        end
                    end
                    ST_RELOAD: k_reg <= k_reg + 1'b1;
                    ST_RESP:
                    begin
                        if (rsp_load && is_update)
                        begin
                            hist_reg[hreg_idx] <= ((hist_reg[hreg_idx] << 1)
                                                   | HIST_W'(req_reg.outcome_taken)) & hmask;
                        end
                    end
                    default:   ;
                endcase
            end
        end
    end

    // Payload: held word, entry tags and targets, slot and response
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (state_reg == ST_CALC)
        begin
            idx_reg <= idx_c;
            hit_reg <= !new_entry;
            if (is_update)
            begin
                tag_reg[idx_c]    <= tag_c;
                target_reg[idx_c] <= req_reg.resolved_target;
            end
        end
        if (state_reg == ST_READ)
        begin
            slot_reg <= unit_slot;
        end
        if (rsp_load)
        begin
            rsp_reg.predict_taken     <= 1'b0;
            rsp_reg.predicted_address <= '0;
            if (!is_update)
            begin
                if (hit_reg && (cnt_rd >= CNT_TAKEN))
                begin
                    rsp_reg.predict_taken     <= 1'b1;
                    rsp_reg.predicted_address <= target_reg[idx_reg];
                end
                else
                begin
                    rsp_reg.predicted_address <= fall_c;
                end
            end
            rsp_reg.branch_count <= branch_reg;
            rsp_reg.flush_count  <= flush_reg;
            rsp_reg.storage_bits <= storage_bits;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_CLK(a_read_then_resp, ram_re |=> (state_reg == ST_RESP) || $past(cfg_write),
                "counter read not followed by response step")
    `ASSERT_CLK(a_reload_per_entry,
                (state_reg == ST_RELOAD) |-> (!cfg.global_table && !cfg.global_history),
                "table reload with shared table or shared history")
    `ASSERT_NEVER(a_accept_busy, req_valid && req_ready && (state_reg != ST_IDLE),
                  "request accepted outside idle")

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for btb_two_level_branch_predictor.
// It predicts every response from its own model of the predictor and compares field by field.
// Depends on btb_pkg and the RTL of the branch target buffer.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import btb_pkg::*;

    localparam int IDLE_LIMIT = 40000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    btb_two_level_branch_predictor DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state: register values as written and the storage they steer
    logic [2:0]  m_entries_log2;
    logic [3:0]  m_history_bits;
    logic [4:0]  m_tag_bits;
    logic [1:0]  m_initial_state;
    logic        m_global_history;
    logic        m_global_table;
    logic [1:0]  m_share_mode;
    logic        m_valid  [MAX_ENTRIES];
    logic [31:0] m_tag    [MAX_ENTRIES];
    logic [31:0] m_target [MAX_ENTRIES];
    logic [31:0] m_hist   [MAX_ENTRIES];
    logic [1:0]  m_counter[TABLE_DEPTH];
    logic [31:0] m_branches;
    logic [31:0] m_flushes;

    rsp_t expected_q[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    int   stall_request = 0;
    bit   sender_busy_mode = 0;
    bit   receiver_busy_mode = 0;

    // Pool of branch addresses that repeat, so entries hit and counters train
    logic [31:0] pool_pc[8];
    logic [31:0] pool_target[8];

    function automatic int eff_log2();
        return (m_entries_log2 > 3'd5) ? 5 : int'(m_entries_log2);
    endfunction

    function automatic int eff_hist();
        if (m_history_bits < 4'd1)
            return 1;
        return (m_history_bits > 4'd8) ? 8 : int'(m_history_bits);
    endfunction

    function automatic int eff_tag();
        return (m_tag_bits > 5'd30) ? 30 : int'(m_tag_bits);
    endfunction

    function automatic void clear_predictor();
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            m_valid[i] = 1'b0;
            m_tag[i] = '0;
            m_target[i] = '0;
            m_hist[i] = '0;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
            m_counter[i] = m_initial_state;
        m_branches = '0;
        m_flushes = '0;
    endfunction

    function automatic int entry_of(logic [31:0] pc);
        return int'((pc >> 2) & ((32'd1 << eff_log2()) - 1));
    endfunction

    function automatic logic [31:0] tag_of(logic [31:0] pc);
        return (pc >> (2 + eff_log2())) & ((32'd1 << eff_tag()) - 1);
    endfunction

    function automatic int slot_of(logic [31:0] pc);
        int h;
        logic [31:0] hmask;
        logic [31:0] share;
        logic [31:0] hist;
        int idx;
        int tbl;
        h = eff_hist();
        hmask = (32'd1 << h) - 1;
        idx = entry_of(pc);
        share = '0;
        hist = m_global_history ? m_hist[0] : m_hist[idx];
        tbl = m_global_table ? 0 : idx;
        if (m_share_mode == SHARE_NEAR)
            share = (pc >> NEAR_SHARE_SHIFT) & hmask;
        else if (m_share_mode == SHARE_FAR)
            share = (pc >> FAR_SHARE_SHIFT) & hmask;
        return ((tbl << h) + int'((hist & hmask) ^ share)) % TABLE_DEPTH;
    endfunction

    function automatic logic [STORAGE_W-1:0] storage_size();
        int n;
        int h;
        int total;
        n = 1 << eff_log2();
        h = eff_hist();
        total = n * (1 + eff_tag() + 30) + (m_global_history ? 1 : n) * h
              + (m_global_table ? 1 : n) * (1 << h) * 2;
        return total[STORAGE_W-1:0];
    endfunction

    // Work out the response to one word and advance the predictor state
    function automatic rsp_t btb_response(req_t w);
        rsp_t r;
        int idx;
        int h;
        int hreg;
        int slot;
        logic [31:0] tag;
        logic [31:0] fall;
        logic [1:0] c;
        idx = entry_of(w.pc);
        tag = tag_of(w.pc);
        fall = w.pc + INSN_BYTES;
        r = '0;
        if (w.func == FUNC_PREDICT)
        begin
            r.predicted_address = fall;
            if (m_valid[idx] && m_tag[idx] == tag && m_counter[slot_of(w.pc)] >= CNT_TAKEN)
            begin
                r.predict_taken = 1'b1;
                r.predicted_address = m_target[idx];
            end
        end
        else
        begin
            h = eff_hist();
            hreg = m_global_history ? 0 : idx;
            m_branches++;
            if ((w.outcome_taken && w.earlier_prediction != w.resolved_target) ||
                (!w.outcome_taken && w.earlier_prediction != fall))
                m_flushes++;
            // new entry with per-entry history: clear history, reload own table if per-entry
            if (!m_global_history && (!m_valid[idx] || m_tag[idx] != tag))
            begin
                m_hist[idx] = '0;
                if (!m_global_table)
                    for (int k = 0; k < (1 << h); k++)
                        m_counter[((idx << h) + k) % TABLE_DEPTH] = m_initial_state;
            end
            m_tag[idx] = tag;
            m_target[idx] = w.resolved_target;
            m_valid[idx] = 1'b1;
            slot = slot_of(w.pc);
            c = m_counter[slot];
            if (w.outcome_taken)
            begin
                if (c < CNT_MAX)
                    c++;
            end
            else if (c > 0)
                c--;
            m_counter[slot] = c;
            m_hist[hreg] = ((m_hist[hreg] << 1) | w.outcome_taken) & ((32'd1 << h) - 1);
        end
        r.branch_count = m_branches;
        r.flush_count = m_flushes;
        r.storage_bits = storage_size();
        return r;
    endfunction

    function automatic int pick_gap(bit busy);
        int r;
        if (!busy)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one word: optional gap, then hold valid until accepted
    task automatic send_word(req_t w);
        int gap;
        gap = pick_gap(sender_busy_mode);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (!req_ready);
        expected_q.push_back(btb_response(w));
    endtask

    task automatic drop_valid();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every response is back, then let the pipeline settle
    task automatic drain();
        drop_valid();
        wait (expected_q.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value, logic [31:0] mask);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx * 4);
        pwdata <= ($urandom & ~mask) | (value & mask);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ENTRIES_LOG2:   m_entries_log2 = value[2:0];
            REG_HISTORY_BITS:   m_history_bits = value[3:0];
            REG_TAG_BITS:       m_tag_bits = value[4:0];
            REG_INITIAL_STATE:  m_initial_state = value[1:0];
            REG_GLOBAL_HISTORY: m_global_history = value[0];
            REG_GLOBAL_TABLE:   m_global_table = value[0];
            REG_SHARE_MODE:     m_share_mode = value[1:0];
            default: ;
        endcase
        clear_predictor();
        // hold the bus idle before the next transfer
        @(posedge clk);
    endtask

    task automatic set_config(int el, int hb, int tb, int ist, int gh, int gt, int sm);
        write_reg(REG_ENTRIES_LOG2, el, 32'h7);
        write_reg(REG_HISTORY_BITS, hb, 32'hF);
        write_reg(REG_TAG_BITS, tb, 32'h1F);
        write_reg(REG_INITIAL_STATE, ist, 32'h3);
        write_reg(REG_GLOBAL_HISTORY, gh, 32'h1);
        write_reg(REG_GLOBAL_TABLE, gt, 32'h1);
        write_reg(REG_SHARE_MODE, sm, 32'h3);
    endtask

    // Fresh address pool; each of the last four entries may alias the index of another one
    task automatic fill_pool();
        for (int i = 0; i < 8; i++)
        begin
            if (i >= 4 && $urandom_range(0, 1))
                pool_pc[i] = pool_pc[i - 4] ^ (32'd1 << $urandom_range(2 + eff_log2(), 31));
            else
                pool_pc[i] = $urandom & ~32'h3;
            pool_target[i] = $urandom;
        end
    endtask

    function automatic req_t pool_word();
        req_t w;
        int i;
        int r;
        i = $urandom_range(0, 7);
        w.func = ($urandom_range(0, 1) != 0) ? FUNC_UPDATE : FUNC_PREDICT;
        w.pc = pool_pc[i];
        w.resolved_target = ($urandom_range(0, 9) == 0) ? $urandom : pool_target[i];
        w.outcome_taken = ($urandom_range(0, 3) != 0) ^ i[0];
        r = $urandom_range(0, 3);
        if (r < 2)
            w.earlier_prediction = w.outcome_taken ? w.resolved_target : w.pc + INSN_BYTES;
        else if (r == 2)
            w.earlier_prediction = w.outcome_taken ? w.pc + INSN_BYTES : w.resolved_target;
        else
            w.earlier_prediction = $urandom;
        return w;
    endfunction

    function automatic req_t noise_word();
        req_t w;
        w.func = ($urandom_range(0, 1) != 0) ? FUNC_UPDATE : FUNC_PREDICT;
        w.pc = $urandom;
        w.resolved_target = $urandom;
        w.outcome_taken = $urandom_range(0, 1);
        w.earlier_prediction = $urandom;
        return w;
    endfunction

    function automatic req_t make_word(func_t f, logic [31:0] pc, logic [31:0] tgt,
                                       logic taken, logic [31:0] prior);
        req_t w;
        w.func = f;
        w.pc = pc;
        w.resolved_target = tgt;
        w.outcome_taken = taken;
        w.earlier_prediction = prior;
        return w;
    endfunction

    // Default registers: cold miss, training to a hit, tag conflict, address extremes
    task automatic test_defaults();
        sender_busy_mode = 0;
        send_word(make_word(FUNC_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0));
        send_word(make_word(FUNC_UPDATE, 32'h0000_0100, 32'h0000_4000, 1'b1, 32'h0000_0104));
        send_word(make_word(FUNC_PREDICT, 32'h0000_0100, 32'h0, 1'b0, 32'h0));
        send_word(make_word(FUNC_UPDATE, 32'h0000_0100, 32'h0000_4000, 1'b1, 32'h0000_4000));
        send_word(make_word(FUNC_PREDICT, 32'h0000_0100, 32'h0, 1'b0, 32'h0));
        send_word(make_word(FUNC_UPDATE, 32'h0000_0100, 32'h0000_4000, 1'b0, 32'h0000_0104));
        send_word(make_word(FUNC_UPDATE, 32'h0000_0100, 32'h0000_4000, 1'b0, 32'h0000_4000));
        // same index, other tag: history and table of the entry start over
        send_word(make_word(FUNC_UPDATE, 32'h8000_0100, 32'hFFFF_FFFF, 1'b1, 32'h0));
        send_word(make_word(FUNC_PREDICT, 32'h0000_0100, 32'h0, 1'b0, 32'h0));
        send_word(make_word(FUNC_PREDICT, 32'h8000_0100, 32'h0, 1'b0, 32'h0));
        send_word(make_word(FUNC_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
        send_word(make_word(FUNC_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0003));
        send_word(make_word(FUNC_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
        send_word(make_word(FUNC_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0));
        drain();
    endtask

    // Register extremes, including values that saturate or fall back
    task automatic test_config_extremes();
        int cfgs[6][7] = '{
            '{0, 1, 0, 0, 0, 0, 0}, '{5, 8, 30, 3, 1, 1, 2}, '{7, 0, 31, 2, 0, 1, 3},
            '{3, 15, 10, 1, 1, 0, 1}, '{2, 4, 5, 0, 0, 0, 2}, '{1, 2, 1, 3, 0, 0, 1}};
        for (int c = 0; c < 6; c++)
        begin
            set_config(cfgs[c][0], cfgs[c][1], cfgs[c][2], cfgs[c][3],
                       cfgs[c][4], cfgs[c][5], cfgs[c][6]);
            fill_pool();
            sender_busy_mode = c[0];
            for (int n = 0; n < 14; n++)
                send_word(pool_word());
            drain();
        end
    endtask

    // Random registers, mostly repeated branches with random outcomes
    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++)
        begin
            set_config($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 31),
                       $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 3));
            fill_pool();
            for (int n = 0; n < 110; n++)
            begin
                if (n % 40 == 0)
                    sender_busy_mode = ~sender_busy_mode;
                if (n % 30 == 0)
                    receiver_busy_mode = ~receiver_busy_mode;
                send_word(($urandom_range(0, 99) < 85) ? pool_word() : noise_word());
            end
            drain();
        end
    endtask

    // Receiver holds off a long time while words keep coming
    task automatic test_backpressure();
        sender_busy_mode = 0;
        stall_request = 300;
        for (int n = 0; n < 20; n++)
            send_word(pool_word());
        drop_valid();
        // sender pauses until every response has come back
        wait (expected_q.size() == 0);
        for (int n = 0; n < 10; n++)
            send_word(pool_word());
        drain();
    endtask

    // Receiver: random stalls, or one long hold when asked
    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            if (stall_request > 0)
            begin
                hold = stall_request;
                stall_request = 0;
                rsp_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            hold = pick_gap(receiver_busy_mode);
            if (hold > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (hold - 1) @(posedge clk);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Compare each response with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t exp_w;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("response with nothing expected");
                error_count++;
            end
            else
            begin
                exp_w = expected_q.pop_front();
                if (rsp.predict_taken !== exp_w.predict_taken)
                begin
                    $error("predict_taken exp %0h got %0h", exp_w.predict_taken,
                           rsp.predict_taken);
                    error_count++;
                end
                if (rsp.predicted_address !== exp_w.predicted_address)
                begin
                    $error("predicted_address exp %0h got %0h", exp_w.predicted_address,
                           rsp.predicted_address);
                    error_count++;
                end
                if (rsp.branch_count !== exp_w.branch_count)
                begin
                    $error("branch_count exp %0h got %0h", exp_w.branch_count,
                           rsp.branch_count);
                    error_count++;
                end
                if (rsp.flush_count !== exp_w.flush_count)
                begin
                    $error("flush_count exp %0h got %0h", exp_w.flush_count, rsp.flush_count);
                    error_count++;
                end
                if (rsp.storage_bits !== exp_w.storage_bits)
                begin
                    $error("storage_bits exp %0h got %0h", exp_w.storage_bits,
                           rsp.storage_bits);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no word or register write moving
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        m_entries_log2 = 3'd5;
        m_history_bits = 4'd8;
        m_tag_bits = 5'd30;
        m_initial_state = 2'd1;
        m_global_history = 1'b0;
        m_global_table = 1'b0;
        m_share_mode = 2'd0;
        clear_predictor();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();
        set_config(5, 8, 30, 1, 0, 0, 0);
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/btb_pkg.sv
rtl/btb_ram.sv
rtl/btb_slot_unit.sv
rtl/btb_cfg_regs.sv
rtl/btb_two_level_branch_predictor.sv
test/testbench.sv
